// ----- rtl/uoa_pkg.sv -----
// shared types and constants for the ultrasonic obstacle avoider
package uoa_pkg;

  // stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned DistW    = 12;
  localparam int unsigned TicksW   = 20;
  localparam int unsigned EchoCntW = 17;

  // floor(w * 17 / 1000) == (w * DistMul) >> DistShift for every w below 2**17
  localparam int unsigned DistShift = 27;
  localparam logic [21:0] DistMul   = 22'd2281702;

  // register reset values
  localparam logic [11:0] ThresholdRst = 12'd50;
  localparam logic [7:0]  TrigPulseRst = 8'd10;
  localparam logic [15:0] RiseToRst    = 16'd10000;
  localparam logic [15:0] FallToRst    = 16'd50000;
  localparam logic [19:0] TurnTimeRst  = 20'd300000;
  localparam logic [19:0] SettleRst    = 20'd50000;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_RIGHT = 2'd2,
    DRV_LEFT  = 2'd3
  } drive_e;

  typedef struct packed {
    logic [11:0] threshold_cm;
    logic [7:0]  trig_pulse;
    logic [15:0] rise_timeout;
    logic [15:0] fall_timeout;
    logic [19:0] turn_time;
    logic [19:0] settle_time;
  } cfg_t;

  typedef struct packed {
    logic             trig_front;
    logic             trig_right;
    logic             trig_left;
    drive_e           motor;
    logic             buzzer;
    logic [DistW-1:0] front_cm;
    logic [DistW-1:0] right_cm;
    logic [DistW-1:0] left_cm;
    logic             done;
  } result_t;

endpackage

// ----- rtl/uoa_cfg.sv -----
// configuration register file with a plain write port
module uoa_cfg
  import uoa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  typedef enum logic [CfgAddrW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_TRIG      = 3'd1,
    CFG_RISE      = 3'd2,
    CFG_FALL      = 3'd3,
    CFG_TURN      = 3'd4,
    CFG_SETTLE    = 3'd5
  } cfg_idx_e;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_cm <= ThresholdRst;
      cfg_q.trig_pulse   <= TrigPulseRst;
      cfg_q.rise_timeout <= RiseToRst;
      cfg_q.fall_timeout <= FallToRst;
      cfg_q.turn_time    <= TurnTimeRst;
      cfg_q.settle_time  <= SettleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_THRESHOLD: cfg_q.threshold_cm <= cfg_wdata_i[11:0];
        CFG_TRIG:      cfg_q.trig_pulse   <= cfg_wdata_i[7:0];
        CFG_RISE:      cfg_q.rise_timeout <= cfg_wdata_i[15:0];
        CFG_FALL:      cfg_q.fall_timeout <= cfg_wdata_i[15:0];
        CFG_TURN:      cfg_q.turn_time    <= cfg_wdata_i[19:0];
        CFG_SETTLE:    cfg_q.settle_time  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/uoa_ranger.sv -----
// ranging sequencer and avoidance decision, one tick per advance
module uoa_ranger
  import uoa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [2:0] echo_i,   // front, right, left from bit 0
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_TRIG   = 3'd0,
    PH_RISE   = 3'd1,
    PH_MEAS   = 3'd2,
    PH_SETTLE = 3'd3,
    PH_TURN   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RG_FRONT = 2'd0,
    RG_RIGHT = 2'd1,
    RG_LEFT  = 2'd2
  } ranger_e;

  phase_e              phase_q, phase_d, cur_phase;
  ranger_e             ranger_q, ranger_d, ranger;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic [EchoCntW-1:0] eht_q, eht_d, eht_inc, width;
  logic [DistW-1:0]    front_q, front_d, right_q, right_d, left_q, left_d;
  drive_e              drive_q, drive_d;
  logic                alarm_q, alarm_d;
  logic [TicksW:0]     ticks_inc;
  logic                echo, finish;
  logic [EchoCntW+21:0] prod;
  logic [DistW-1:0]    cm;

  always_comb begin
    case (phase_q)
      PH_RISE, PH_MEAS, PH_SETTLE, PH_TURN: cur_phase = phase_q;
      default:                              cur_phase = PH_TRIG;
    endcase
    case (ranger_q)
      RG_RIGHT: ranger = RG_RIGHT;
      RG_LEFT:  ranger = RG_LEFT;
      default:  ranger = RG_FRONT;
    endcase
  end

  always_comb begin
    case (ranger)
      RG_RIGHT: echo = echo_i[1];
      RG_LEFT:  echo = echo_i[2];
      default:  echo = echo_i[0];
    endcase
  end

  assign ticks_inc = {1'b0, ticks_q} + {{TicksW{1'b0}}, 1'b1};
  assign eht_inc   = eht_q + {{(EchoCntW-1){1'b0}}, 1'b1};

  // distance in cm through a reciprocal multiply
  assign prod = {{22{1'b0}}, width} * {{EchoCntW{1'b0}}, DistMul};
  assign cm   = prod[DistShift +: DistW];

  always_comb begin
    phase_d  = cur_phase;
    ranger_d = ranger;
    ticks_d  = ticks_q;
    eht_d    = eht_q;
    front_d  = front_q;
    right_d  = right_q;
    left_d   = left_q;
    drive_d  = drive_q;
    alarm_d  = alarm_q;
    finish   = 1'b0;
    width    = '0;

    case (cur_phase)
      PH_RISE: begin
        if (echo) begin
          eht_d   = {{(EchoCntW-1){1'b0}}, 1'b1};
          phase_d = PH_MEAS;
          if ({{(EchoCntW-1){1'b0}}, 1'b1} >= {1'b0, cfg_i.fall_timeout}) begin
            finish = 1'b1;
            width  = {{(EchoCntW-1){1'b0}}, 1'b1};
          end
        end else if (ticks_inc >= {5'd0, cfg_i.rise_timeout}) begin
          eht_d  = '0;
          finish = 1'b1;
        end else begin
          ticks_d = ticks_inc[TicksW-1:0];
        end
      end
      PH_MEAS: begin
        if (echo) begin
          eht_d = eht_inc;
          if (eht_inc >= {1'b0, cfg_i.fall_timeout}) begin
            finish = 1'b1;
            width  = eht_inc;
          end
        end else begin
          finish = 1'b1;
          width  = eht_q;
        end
      end
      PH_SETTLE: begin
        if (ticks_inc >= {1'b0, cfg_i.settle_time}) begin
          ticks_d = '0;
          eht_d   = '0;
          phase_d = PH_TRIG;
          if (front_q < cfg_i.threshold_cm) begin
            alarm_d  = 1'b1;
            drive_d  = DRV_STOP;
            ranger_d = RG_RIGHT;
          end else begin
            alarm_d  = 1'b0;
            drive_d  = DRV_FWD;
            ranger_d = RG_FRONT;
          end
        end else begin
          ticks_d = ticks_inc[TicksW-1:0];
        end
      end
      PH_TURN: begin
        if (ticks_inc >= {1'b0, cfg_i.turn_time}) begin
          drive_d  = DRV_STOP;
          ranger_d = RG_FRONT;
          phase_d  = PH_TRIG;
          ticks_d  = '0;
          eht_d    = '0;
        end else begin
          ticks_d = ticks_inc[TicksW-1:0];
        end
      end
      default: begin
        if (ticks_inc >= {13'd0, cfg_i.trig_pulse}) begin
          phase_d = PH_RISE;
          ticks_d = '0;
        end else begin
          phase_d = PH_TRIG;
          ticks_d = ticks_inc[TicksW-1:0];
        end
      end
    endcase

    // end of a ranging: store the distance and pick what follows
    if (finish) begin
      ticks_d = '0;
      case (ranger)
        RG_RIGHT: begin
          right_d  = cm;
          ranger_d = RG_LEFT;
          phase_d  = PH_TRIG;
          eht_d    = '0;
        end
        RG_LEFT: begin
          left_d  = cm;
          drive_d = (right_q > cm) ? DRV_RIGHT : DRV_LEFT;
          phase_d = PH_TURN;
        end
        default: begin
          front_d = cm;
          phase_d = PH_SETTLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TRIG;
      ranger_q <= RG_FRONT;
      ticks_q  <= '0;
      eht_q    <= '0;
      front_q  <= '0;
      right_q  <= '0;
      left_q   <= '0;
      drive_q  <= DRV_FWD;
      alarm_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      ranger_q <= ranger_d;
      ticks_q  <= ticks_d;
      eht_q    <= eht_d;
      front_q  <= front_d;
      right_q  <= right_d;
      left_q   <= left_d;
      drive_q  <= drive_d;
      alarm_q  <= alarm_d;
    end
  end

  // pin levels are those held during the tick; distances show this tick's update
  always_comb begin
    res_o.trig_front = (cur_phase == PH_TRIG) && (ranger == RG_FRONT);
    res_o.trig_right = (cur_phase == PH_TRIG) && (ranger == RG_RIGHT);
    res_o.trig_left  = (cur_phase == PH_TRIG) && (ranger == RG_LEFT);
    res_o.motor      = drive_q;
    res_o.buzzer     = alarm_q;
    res_o.front_cm   = front_d;
    res_o.right_cm   = right_d;
    res_o.left_cm    = left_d;
    res_o.done       = finish;
  end

endmodule

// ----- rtl/uoa_skid.sv -----
// output register with a skid stage
module uoa_skid
  import uoa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    ready_i
);

  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  logic    push, out_free;

  assign ready_o  = !skid_valid_q;
  assign push     = valid_i && ready_o;
  assign out_free = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (push) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

// ----- rtl/ultrasonic_obstacle_avoider_core.sv -----
// top level of the three-ranger ultrasonic obstacle avoider
// Each input item is one microsecond tick carrying the three echo pin levels, and each
// one yields exactly one result item with the trigger pins, motor command, buzzer,
// the three latest distances and a one-tick ranging_done flag. The block cycles
// through trigger, echo-rise wait and echo-width count for the front ranger, pauses
// for the settle time, and then either drives forward and ranges the front again or,
// when the front distance is below the threshold, sounds the buzzer, stops, ranges
// right and left and turns toward the larger side (left on a tie) for the turn time.
// Distance is floor(width * 17 / 1000) cm, formed by one reciprocal multiply.
// Throughput is one item per clock while the output is not back-pressured; an accepted
// item passes the input register, then the sequencer step into the output register.
// The output side has a skid stage, so an item is still taken while a result waits.
// Trigger, motor and buzzer fields give the levels held during that tick.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the user must
// write it only while the stream is idle, the block does not enforce this. Indexes
// 0..5: threshold, trigger pulse, rise/fall timeout, turn/settle time; others ignored.
module ultrasonic_obstacle_avoider_core
  import uoa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // tick items in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // echo_front, echo_right, echo_left, zeros
  // result items out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // trigger_front, trigger_right, trigger_left,
                                              // motor_command[1:0], buzzer_on, front_cm[11:0],
                                              // right_cm[11:0], left_cm[11:0], ranging_done,
                                              // zeros
);

  cfg_t       cfg;
  result_t    res, out_res;
  logic       in_valid_q;
  logic [2:0] echo_q;
  logic       buf_ready, adv, in_take;

  uoa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register: one tick waits here while the sequencer steps
  assign adv           = in_valid_q && buf_ready;
  assign s_axis_tready = !in_valid_q || buf_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      echo_q <= s_axis_tdata[2:0];
    end
  end

  // sequencer state advances once per tick item
  uoa_ranger u_ranger (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .echo_i (echo_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register plus skid stage
  uoa_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .ready_i (m_axis_tready)
  );

  // pack the result fields from bit 0 upward
  assign m_axis_tdata = {5'd0,
                         out_res.done,
                         out_res.left_cm,
                         out_res.right_cm,
                         out_res.front_cm,
                         out_res.buzzer,
                         out_res.motor,
                         out_res.trig_left,
                         out_res.trig_right,
                         out_res.trig_front};

endmodule
